// ===== design/sma_pkg.sv =====
// ----------------------------------------------------------------------------
// sma_pkg: shared types and constants for the stack machine ALU
// Opcodes, status codes, request/response structs, cell and sequencer types.
// ----------------------------------------------------------------------------
package sma_pkg;

   localparam int DATA_W      = 64;
   localparam int STEP_W      = $clog2(DATA_W);
   localparam int STACK_DEPTH = 32;
   localparam int RSP_DEPTH_W = 6;

   typedef enum logic [2:0] {
      OP_PUSH = 3'd0,
      OP_ADD  = 3'd1,
      OP_SUB  = 3'd2,
      OP_MUL  = 3'd3,
      OP_DIV  = 3'd4,
      OP_OUT  = 3'd5,
      OP_HALT = 3'd6
   } op_type;

   typedef enum logic [2:0] {
      STAT_OK     = 3'd0,
      STAT_UNDER  = 3'd1,
      STAT_OVER   = 3'd2,
      STAT_DIVZ   = 3'd3,
      STAT_HALTED = 3'd4
   } status_type;

   typedef enum logic [1:0] {
      CELL_HOLD = 2'd0,
      CELL_PREV = 2'd1,
      CELL_NEXT = 2'd2
   } cell_mode_type;

   typedef enum logic {
      SM_IDLE = 1'b0,
      SM_CALC = 1'b1
   } state_type;

   typedef struct packed {
      logic [2:0]               op;
      logic signed [DATA_W-1:0] operand;
   } req_type;

   typedef struct packed {
      logic [2:0]               status;
      logic                     out_valid;
      logic signed [DATA_W-1:0] out_value;
      logic [RSP_DEPTH_W-1:0]   depth;
   } rsp_type;

   // start request to the multiply/divide sequencer
   typedef struct packed {
      logic              start;
      logic              is_div;
      logic [DATA_W-1:0] a;
      logic [DATA_W-1:0] b;
   } md_req_type;

endpackage

// ===== design/stack_machine_alu.sv =====
// ----------------------------------------------------------------------------
// stack_machine_alu: small stack machine, one instruction per request
// Operand stack built as a row of shifting cells plus a bit-serial mul/div.
// ----------------------------------------------------------------------------
// Push, add, sub, out, halt and every refused request answer in the cycle
//   after acceptance; busy stays low, so one request per cycle.
// Mul and div run on the bit-serial unit; busy is high while it runs one
//   bit per cycle, and no request is accepted until the answer comes.
// Reset (synchronous): stack empty, halted flag clear, no response pending.
// Responses are strobed for one cycle; the receiver cannot stall.
// ----------------------------------------------------------------------------
module stack_machine_alu
   import sma_pkg::*;
#(
   parameter int STACK_DEPTH = sma_pkg::STACK_DEPTH
)
(
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   input  req_type req_payload,
   output logic    busy,
   output logic    rsp_strobe,
   output rsp_type rsp_payload
);

   localparam int DEPTH_W = $clog2(STACK_DEPTH + 1);
   localparam logic [DEPTH_W-1:0] DEPTH_FULL = DEPTH_W'(STACK_DEPTH);

   // control state
   state_type          state_ff, state_in;
   logic [DEPTH_W-1:0] depth_ff, depth_in;
   logic               halted_ff, halted_in;
   logic               rsp_strobe_ff, rsp_strobe_in;
   rsp_type            rsp_ff, rsp_in;

   // cell row controls
   logic               shift_dn;     // push: every entry moves one place down
   logic               shift_up;     // pop: every entry moves one place up
   logic               load_top;     // with shift_up: top takes the ALU result
   logic [DATA_W-1:0]  alu_result;
   logic [DATA_W-1:0]  top_load;
   cell_mode_type      cell_mode  [STACK_DEPTH];
   logic [DATA_W-1:0]  cell_value [STACK_DEPTH];
   logic [DATA_W-1:0]  prev_in    [STACK_DEPTH];
   logic [DATA_W-1:0]  next_in    [STACK_DEPTH];

   // mul/div sequencer
   md_req_type         md_req;
   logic               md_done;
   logic [DATA_W-1:0]  md_result;

   logic               accept;
   logic [DEPTH_W+RSP_DEPTH_W-1:0] depth_ext;

   assign accept    = start && (state_ff == SM_IDLE);
   assign depth_ext = {{RSP_DEPTH_W{1'b0}}, depth_in};

   // ------------------------------------------------------------------------
   // Sequencer: decode, stack checks, cell controls and response
   // ------------------------------------------------------------------------
   always_comb begin
      state_in      = state_ff;
      depth_in      = depth_ff;
      halted_in     = halted_ff;
      rsp_strobe_in = 1'b0;
      shift_dn      = 1'b0;
      shift_up      = 1'b0;
      load_top      = 1'b0;
      alu_result    = md_result;
      md_req.start  = 1'b0;
      md_req.is_div = (req_payload.op == OP_DIV);
      md_req.a      = cell_value[1];   // second entry
      md_req.b      = cell_value[0];   // top entry
      rsp_in.status    = STAT_OK;
      rsp_in.out_valid = 1'b0;
      rsp_in.out_value = '0;
      rsp_in.depth     = '0;

      unique case (state_ff)
         SM_IDLE: begin
            if (accept) begin
               rsp_strobe_in = 1'b1;
               if (halted_ff) begin
                  rsp_in.status = STAT_HALTED;
               end else begin
                  unique case (req_payload.op) inside
                     OP_PUSH: begin
                        if (depth_ff == DEPTH_FULL) begin
                           rsp_in.status = STAT_OVER;
                        end else begin
                           shift_dn = 1'b1;
                           depth_in = depth_ff + DEPTH_W'(1);
                        end
                     end
                     OP_ADD, OP_SUB: begin
                        if (depth_ff < DEPTH_W'(2)) begin
                           rsp_in.status = STAT_UNDER;
                        end else begin
                           alu_result = (req_payload.op == OP_ADD) ?
                                        cell_value[1] + cell_value[0] :
                                        cell_value[1] - cell_value[0];
                           shift_up = 1'b1;
                           load_top = 1'b1;
                           depth_in = depth_ff - DEPTH_W'(1);
                        end
                     end
                     OP_MUL, OP_DIV: begin
                        if (depth_ff < DEPTH_W'(2)) begin
                           rsp_in.status = STAT_UNDER;
                        end else if (req_payload.op == OP_DIV &&
                                     cell_value[0] == '0) begin
                           rsp_in.status = STAT_DIVZ;
                        end else begin
                           // answer comes when the sequencer finishes
                           md_req.start  = 1'b1;
                           rsp_strobe_in = 1'b0;
                           state_in      = SM_CALC;
                        end
                     end
                     OP_OUT: begin
                        if (depth_ff == '0) begin
                           rsp_in.status = STAT_UNDER;
                        end else begin
                           shift_up         = 1'b1;
                           depth_in         = depth_ff - DEPTH_W'(1);
                           rsp_in.out_valid = 1'b1;
                           rsp_in.out_value = cell_value[0];
                        end
                     end
                     OP_HALT: begin
                        halted_in = 1'b1;
                     end
                     default: begin
                        // unused opcode: no effect, status ok
                     end
                  endcase
               end
            end
         end
         SM_CALC: begin
            if (md_done) begin
               shift_up      = 1'b1;
               load_top      = 1'b1;
               depth_in      = depth_ff - DEPTH_W'(1);
               rsp_strobe_in = 1'b1;
               state_in      = SM_IDLE;
            end
         end
         default: begin
            state_in = SM_IDLE;
         end
      endcase

      rsp_in.depth = depth_ext[RSP_DEPTH_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= SM_IDLE;
         depth_ff      <= '0;
         halted_ff     <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         depth_ff      <= depth_in;
         halted_ff     <= halted_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
      rsp_ff <= rsp_in;
   end

   // ------------------------------------------------------------------------
   // Cell row: entry 0 is the top of stack
   // ------------------------------------------------------------------------
   assign top_load = shift_dn ? req_payload.operand : alu_result;

   always_comb begin
      for (int i = 0; i < STACK_DEPTH; i++) begin
         prev_in[i] = (i == 0) ? top_load : cell_value[(i == 0) ? 0 : i - 1];
         next_in[i] = (i == STACK_DEPTH - 1) ? '0 :
                      cell_value[(i == STACK_DEPTH - 1) ? i : i + 1];
         if (shift_dn) begin
            cell_mode[i] = CELL_PREV;
         end else if (shift_up) begin
            cell_mode[i] = (i == 0 && load_top) ? CELL_PREV : CELL_NEXT;
         end else begin
            cell_mode[i] = CELL_HOLD;
         end
      end
   end

   for (genvar g = 0; g < STACK_DEPTH; g++) begin : g_cell
      sma_cell u_cell (
         .clock      (clock),
         .mode       (cell_mode[g]),
         .prev_value (prev_in[g]),
         .next_value (next_in[g]),
         .value      (cell_value[g])
      );
   end

   sma_muldiv u_muldiv (
      .clock  (clock),
      .reset  (reset),
      .md_req (md_req),
      .done   (md_done),
      .result (md_result)
   );

   assign busy        = (state_ff == SM_CALC);
   assign rsp_strobe  = rsp_strobe_ff;
   assign rsp_payload = rsp_ff;

   // ------------------------------------------------------------------------
   // Checks
   // ------------------------------------------------------------------------
   a_rsp_when_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe_ff |-> !busy)
      else $error("response strobed while sequencer busy");

   a_depth_bound: assert property (@(posedge clock) disable iff (reset)
      depth_ff <= DEPTH_FULL)
      else $error("stack depth beyond capacity");

   a_halt_sticky: assert property (@(posedge clock) disable iff (reset)
      halted_ff |=> halted_ff)
      else $error("halted flag cleared without reset");

   a_quick_rsp: assert property (@(posedge clock) disable iff (reset)
      (accept && (halted_ff || (req_payload.op != OP_MUL &&
                                req_payload.op != OP_DIV))) |=> rsp_strobe_ff)
      else $error("single-cycle request produced no response");

   a_md_done_calc: assert property (@(posedge clock) disable iff (reset)
      md_done |-> (state_ff == SM_CALC))
      else $error("mul/div finished outside of calc state");

endmodule

// ===== design/sma_cell.sv =====
// ----------------------------------------------------------------------------
// sma_cell: one stack entry
// Holds its value, or takes the neighbor's value toward the top or bottom.
// ----------------------------------------------------------------------------
module sma_cell
   import sma_pkg::*;
(
   input  logic                clock,
   input  cell_mode_type       mode,
   input  logic [DATA_W-1:0]   prev_value,
   input  logic [DATA_W-1:0]   next_value,
   output logic [DATA_W-1:0]   value
);

   logic [DATA_W-1:0] value_ff;
   logic [DATA_W-1:0] value_in;

   always_comb begin
      case (mode)
         CELL_PREV: value_in = prev_value;
         CELL_NEXT: value_in = next_value;
         default:   value_in = value_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign value = value_ff;

endmodule

// ===== design/sma_muldiv.sv =====
// ----------------------------------------------------------------------------
// sma_muldiv: bit-serial multiply / signed divide
// Shift-add multiply (low 64 bits) or restoring divide, one bit per cycle.
// ----------------------------------------------------------------------------
module sma_muldiv
   import sma_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  md_req_type        md_req,
   output logic              done,
   output logic [DATA_W-1:0] result
);

   localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(DATA_W - 1);

   function automatic logic [DATA_W-1:0] mag(input logic [DATA_W-1:0] v);
      mag = v[DATA_W-1] ? (~v + DATA_W'(1)) : v;
   endfunction

   logic              run_ff,  run_in;
   logic              done_ff, done_in;
   logic              div_ff,  div_in;
   logic              neg_ff,  neg_in;
   logic [STEP_W-1:0] cnt_ff,  cnt_in;
   logic [DATA_W-1:0] x_ff,    x_in;   // multiplicand, or dividend/quotient
   logic [DATA_W-1:0] y_ff,    y_in;   // multiplier, or divisor
   logic [DATA_W-1:0] acc_ff,  acc_in; // product, or remainder
   logic [DATA_W:0]   shifted;
   logic [DATA_W:0]   diff;

   always_comb begin
      run_in  = run_ff;
      done_in = 1'b0;
      div_in  = div_ff;
      neg_in  = neg_ff;
      cnt_in  = cnt_ff;
      x_in    = x_ff;
      y_in    = y_ff;
      acc_in  = acc_ff;
      shifted = {acc_ff, x_ff[DATA_W-1]};
      diff    = shifted - {1'b0, y_ff};

      if (md_req.start && !run_ff) begin
         run_in = 1'b1;
         div_in = md_req.is_div;
         neg_in = md_req.a[DATA_W-1] ^ md_req.b[DATA_W-1];
         cnt_in = '0;
         acc_in = '0;
         x_in   = md_req.is_div ? mag(md_req.a) : md_req.a;
         y_in   = md_req.is_div ? mag(md_req.b) : md_req.b;
      end else if (run_ff) begin
         cnt_in = cnt_ff + STEP_W'(1);
         if (div_ff) begin
            if (!diff[DATA_W]) begin
               acc_in = diff[DATA_W-1:0];
               x_in   = {x_ff[DATA_W-2:0], 1'b1};
            end else begin
               acc_in = shifted[DATA_W-1:0];
               x_in   = {x_ff[DATA_W-2:0], 1'b0};
            end
         end else begin
            if (y_ff[0]) begin
               acc_in = acc_ff + x_ff;
            end
            x_in = {x_ff[DATA_W-2:0], 1'b0};
            y_in = {1'b0, y_ff[DATA_W-1:1]};
         end
         if (cnt_ff == STEP_LAST) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
      div_ff <= div_in;
      neg_ff <= neg_in;
      cnt_ff <= cnt_in;
      x_ff   <= x_in;
      y_ff   <= y_in;
      acc_ff <= acc_in;
   end

   assign done   = done_ff;
   assign result = div_ff ? (neg_ff ? (~x_ff + DATA_W'(1)) : x_ff) : acc_ff;

endmodule
